/* sv/pgp_pkg.sv */
// Shared constants and types for the presence gap penalty unit.
// No dependencies; every other file of the block imports this package.
package pgp_pkg;

    // Field and port widths
    localparam int DATA_W     = 64;
    localparam int RESULT_W   = 16;
    localparam int CFG_W      = 7;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    // Register map (word index)
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_COLUMNS = 1'b0;

    // Defaults handed to the top-level parameters
    localparam int COLUMNS_DEF  = 64;
    localparam int MAX_ROWS_DEF = 1024;

    // Reset value of the column count register
    localparam logic [CFG_W-1:0] ACTIVE_COLUMNS_RST = 7'd64;

    // Total saturation point
    localparam logic [RESULT_W-1:0] TOTAL_CAP = 16'hFFFF;

    // Lanes summed together in the first merge stage
    localparam int LANES_PER_GROUP = 8;

    // Control that travels with one row down the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } row_ctrl_t;

endpackage : pgp_pkg

/* sv/presence_gap_penalty_unit.sv */
// Pipeline: an accepted row loads the column lanes, then the group sum stage, then the
// total and the result register that drives m_tvalid.
// Throughput: one row per cycle; every column lane updates in parallel on each accepted row,
// and only a last row waiting on a full result register holds s_tready low.
// Reset: synchronous, active low; clears column state, total, valid flags, and
// sets active_columns to 64.
module presence_gap_penalty_unit #(
    parameter int COLUMNS  = pgp_pkg::COLUMNS_DEF,
    parameter int MAX_ROWS = pgp_pkg::MAX_ROWS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Row input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pgp_pkg::DATA_W-1:0]       s_tdata,   // [63:0] presence_bits
    input  logic                             s_tlast,   // last_row
    // Result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pgp_pkg::RESULT_W-1:0]     m_tdata,   // [15:0] gap_penalty
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pgp_pkg::PADDR_W-1:0]      paddr,
    input  logic [pgp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pgp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import pgp_pkg::*;

    localparam int PEND_W = $clog2(MAX_ROWS);

    logic [CFG_W-1:0]                  active_columns_reg;
    logic                              a_valid_reg, a_last_reg;
    logic                              accept, a_take, cfg_write;
    row_ctrl_t                         lane_cmd, a_ctrl;
    logic [COLUMNS-1:0][PEND_W-1:0]    contrib;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_columns_reg <= ACTIVE_COLUMNS_RST;
        end else if (cfg_write && (paddr[PADDR_W-1:2] == REG_ACTIVE_COLUMNS)) begin
            active_columns_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_ACTIVE_COLUMNS: prdata = APB_DATA_W'(active_columns_reg);
            default:            prdata = '0;
        endcase
    end

    // Input handshake: stage A frees up as the merge takes its word
    assign s_tready = !a_valid_reg || a_take;
    assign accept   = s_tvalid && s_tready;

    assign lane_cmd.valid = accept;
    assign lane_cmd.last  = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_take) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_last_reg <= s_tlast;
        end
    end

    assign a_ctrl.valid = a_valid_reg;
    assign a_ctrl.last  = a_last_reg;

    // One lane per column
    for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
        pgp_lane #(
            .MAX_ROWS (MAX_ROWS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (lane_cmd),
            .active  (CFG_W'(c) < active_columns_reg),
            .present (s_tdata[c]),
            .contrib (contrib[c])
        );
    end

    // Combine lane contributions into the total
    pgp_merge #(
        .COLUMNS  (COLUMNS),
        .MAX_ROWS (MAX_ROWS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .a_ctrl   (a_ctrl),
        .contrib  (contrib),
        .a_take   (a_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_stall_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> a_valid_reg)
        else $error("input stalled with an empty lane stage");
`endif

endmodule : presence_gap_penalty_unit

/* sv/pgp_lane.sv */
// One column lane: seen flag, pending absence count and the row's contribution.
// Depends on pgp_pkg.
module pgp_lane #(
    parameter int MAX_ROWS = pgp_pkg::MAX_ROWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pgp_pkg::row_ctrl_t            cmd,
    input  logic                          active,
    input  logic                          present,
    output logic [$clog2(MAX_ROWS)-1:0]   contrib
);
    import pgp_pkg::*;

    localparam int PEND_W = $clog2(MAX_ROWS);
    localparam logic [PEND_W-1:0] PEND_CAP = PEND_W'(MAX_ROWS - 1);

    logic              seen_reg, seen_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [PEND_W-1:0] contrib_reg, contrib_next;

    // Update the column on each accepted row; clear seen flag and pending count on the last row
    always_comb begin
        seen_next    = seen_reg;
        pending_next = pending_reg;
        contrib_next = '0;
        if (active) begin
            if (present) begin
                if (seen_reg) begin
                    contrib_next = pending_reg;
                end
                pending_next = '0;
                seen_next    = 1'b1;
            end else if (seen_reg && (pending_reg != PEND_CAP)) begin
                pending_next = pending_reg + PEND_W'(1);
            end
        end
        if (cmd.last) begin
            seen_next    = 1'b0;
            pending_next = '0;
        end
    end

    // Column state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 1'b0;
            pending_reg <= '0;
        end else if (cmd.valid) begin
            seen_reg    <= seen_next;
            pending_reg <= pending_next;
        end
    end

    // Contribution word; held while the next stage stalls
    always_ff @(posedge aclk) begin
        if (cmd.valid) begin
            contrib_reg <= contrib_next;
        end
    end

    assign contrib = contrib_reg;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.valid && cmd.last) |=> (!seen_reg && (pending_reg == '0)))
        else $error("lane state not cleared after last row");

    a_pending_needs_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg != '0) |-> seen_reg)
        else $error("pending absences without a seen presence");
`endif

endmodule : pgp_lane

/* sv/pgp_merge.sv */
// Merge stage: sums lane contributions in groups, accumulates the running total
// and holds the result word. Depends on pgp_pkg.
module pgp_merge #(
    parameter int COLUMNS  = pgp_pkg::COLUMNS_DEF,
    parameter int MAX_ROWS = pgp_pkg::MAX_ROWS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  pgp_pkg::row_ctrl_t                          a_ctrl,
    input  logic [COLUMNS-1:0][$clog2(MAX_ROWS)-1:0]    contrib,
    output logic                                        a_take,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [pgp_pkg::RESULT_W-1:0]                m_tdata
);
    import pgp_pkg::*;

    localparam int PEND_W  = $clog2(MAX_ROWS);
    localparam int NGROUPS = (COLUMNS + LANES_PER_GROUP - 1) / LANES_PER_GROUP;
    localparam int GROUP_W = PEND_W + 3;
    localparam int ROW_W   = GROUP_W + 3;
    localparam int SUM_W   = ((ROW_W > RESULT_W) ? ROW_W : RESULT_W) + 1;

    logic [NGROUPS-1:0][GROUP_W-1:0] group_next;
    logic [NGROUPS-1:0][GROUP_W-1:0] group_reg;
    logic                            b_valid_reg, b_last_reg;
    logic [ROW_W-1:0]                row_sum;
    logic [SUM_W-1:0]                sum_wide;
    logic [RESULT_W-1:0]             sum_sat;
    logic [RESULT_W-1:0]             total_reg, total_next;
    logic                            out_valid_reg;
    logic [RESULT_W-1:0]             out_data_reg;
    logic                            out_free, b_take, b_ready;

    // First level: add each group of lanes
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < LANES_PER_GROUP; k++) begin
                if (g * LANES_PER_GROUP + k < COLUMNS) begin
                    group_next[g] = group_next[g]
                        + GROUP_W'(contrib[g * LANES_PER_GROUP + k]);
                end
            end
        end
    end

    // Second level: add the groups, then the total, saturating
    always_comb begin
        row_sum = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            row_sum = row_sum + ROW_W'(group_reg[g]);
        end
        sum_wide = SUM_W'(total_reg) + SUM_W'(row_sum);
        sum_sat  = (sum_wide > SUM_W'(TOTAL_CAP)) ? TOTAL_CAP : sum_wide[RESULT_W-1:0];
    end

    // Flow control: a last row waits for a free result slot
    assign out_free = !out_valid_reg || m_tready;
    assign b_take   = b_valid_reg && (!b_last_reg || out_free);
    assign b_ready  = !b_valid_reg || b_take;
    assign a_take   = a_ctrl.valid && b_ready;

    always_comb begin
        total_next = total_reg;
        if (b_take) begin
            total_next = b_last_reg ? '0 : sum_sat;
        end
    end

    // Group sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_take) begin
            group_reg  <= group_next;
            b_last_reg <= a_ctrl.last;
        end
    end

    // Running total and result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            if (b_take && b_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_take && b_last_reg) begin
            out_data_reg <= sum_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_total_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_take && b_last_reg) |=> (total_reg == '0))
        else $error("running total not cleared after last row");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(b_take && b_last_reg))
        else $error("result word raised without a last row");
`endif

endmodule : pgp_merge

/* verif/pgp_tb_pkg.sv */
// Scoreboard for the presence gap penalty unit: tracks column state per row
// and holds the penalties expected on the result stream. Depends on pgp_pkg.
package pgp_tb_pkg;
    import pgp_pkg::*;

    localparam int              SCORED_MAX   = COLUMNS_DEF;
    localparam logic [9:0]      PENDING_CAP  = 10'(MAX_ROWS_DEF - 1);
    localparam int              REPORT_LIMIT = 10;

    class gap_penalty_scoreboard;
        logic [CFG_W-1:0]    active_columns;
        logic                seen[SCORED_MAX];
        logic [9:0]          pending[SCORED_MAX];
        logic [RESULT_W-1:0] total;
        logic [RESULT_W-1:0] expected_penalties[$];
        int unsigned         failures;

        function new();
            failures = 0;
            active_columns = ACTIVE_COLUMNS_RST;
            clear_matrix();
        endfunction

        // Drop all column state at the end of a matrix
        function void clear_matrix();
            for (int c = 0; c < SCORED_MAX; c++) begin
                seen[c] = 1'b0;
                pending[c] = '0;
            end
            total = '0;
        endfunction

        function void set_columns(logic [CFG_W-1:0] value);
            active_columns = value;
        endfunction

        // Advance the column state by one accepted row word
        function void note_row(logic [DATA_W-1:0] bits, logic last);
            int unsigned         scored;
            logic [RESULT_W:0]   sum;
            scored = (active_columns > SCORED_MAX) ? SCORED_MAX : active_columns;
            for (int c = 0; c < scored; c++) begin
                if (bits[c]) begin
                    // Charge the absences held since the previous presence
                    if (seen[c]) begin
                        sum = {1'b0, total} + pending[c];
                        total = (sum > TOTAL_CAP) ? TOTAL_CAP : sum[RESULT_W-1:0];
                    end
                    pending[c] = '0;
                    seen[c] = 1'b1;
                end else if (seen[c] && pending[c] < PENDING_CAP) begin
                    pending[c]++;
                end
            end
            if (last) begin
                // Queue the penalty behind the ones still outstanding
                expected_penalties = {expected_penalties, total};
                clear_matrix();
            end
        endfunction

        function void report(string msg);
            if (failures < REPORT_LIMIT)
                $display("%s", msg);
            failures++;
        endfunction

        // Compare one result word with the oldest expected penalty
        function void check_penalty(logic [RESULT_W-1:0] actual);
            logic [RESULT_W-1:0] want;
            if (expected_penalties.size() == 0) begin
                report($sformatf("unexpected penalty word: got %0d", actual));
            end else begin
                want = expected_penalties.pop_front();
                if (actual !== want)
                    report($sformatf("gap_penalty mismatch: expected %0d, got %0d",
                                     want, actual));
            end
        endfunction

        function void close_out();
            if (expected_penalties.size() != 0)
                report($sformatf("%0d expected penalties never arrived",
                                 expected_penalties.size()));
        endfunction
    endclass

endpackage : pgp_tb_pkg

/* verif/tb_top.sv */
// Top-level testbench for presence_gap_penalty_unit: drives rows and APB writes,
// checks every penalty word against the scoreboard. Depends on pgp_pkg, pgp_tb_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pgp_pkg::*;
    import pgp_tb_pkg::*;

    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 SETTLE       = 8;
    localparam logic [PADDR_W-1:0] COLUMNS_ADDR = {REG_ACTIVE_COLUMNS, 2'b00};

    typedef enum {ROW_RANDOM, ROW_SPARSE, ROW_DENSE, ROW_FLAT} row_mix_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;   // [63:0] presence_bits
    logic                  s_tlast  = 1'b0; // last_row
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RESULT_W-1:0]   m_tdata;         // [15:0] gap_penalty
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles         = 0;

    gap_penalty_scoreboard board = new();

    presence_gap_penalty_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted penalty word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_penalty(m_tdata);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] make_row(row_mix_t mix);
        logic [DATA_W-1:0] a, b, c;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        c = {$urandom(), $urandom()};
        case (mix)
            ROW_SPARSE: return a & b & c;
            ROW_DENSE:  return a | b | c;
            ROW_FLAT:   return $urandom_range(1) ? '1 : '0;
            default:    return a;
        endcase
    endfunction

    // Present one row word, idling first at random; leave tvalid high after it
    task automatic send_row(logic [DATA_W-1:0] bits, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_row(bits, last);
    endtask

    // Hold the sender until every expected penalty is back and the pipe is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.expected_penalties.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write active_columns, then read it back
    task automatic write_columns(logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] noise;
        noise = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLUMNS_ADDR;
        pwdata  <= {noise[APB_DATA_W-1:CFG_W], value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_columns(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[CFG_W-1:0] !== value)
            board.report($sformatf("active_columns readback: expected %0d, got %0d",
                                   value, prdata[CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stream whole matrices of random length and density
    task automatic run_matrices(int unsigned rows_wanted);
        int unsigned sent;
        int unsigned len;
        row_mix_t    mix;
        sent = 0;
        while (sent < rows_wanted) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
            mix = row_mix_t'($urandom_range(3));
            for (int r = 0; r < len; r++)
                send_row(make_row(mix), r == len - 1);
            sent += len;
            if ($urandom_range(11) == 0)
                drain_results();
        end
    endtask

    initial begin
        logic [CFG_W-1:0] cfg_seq [9];
        int unsigned      send_pcts [3];
        int unsigned      recv_pcts [3];

        send_pcts = '{29, 74, 0};
        recv_pcts = '{74, 29, 0};
        cfg_seq = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'($urandom_range(127)),
                    7'($urandom_range(64, 1)), 7'd2, 7'd64};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = send_pcts[0];
        recv_stall_pct = recv_pcts[0];

        // Single-row matrices: full and empty
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        // Mixed gaps across all columns
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);
        // Trailing absences stay uncharged; untouched columns charge nothing
        send_row(64'h1, 1'b0);
        send_row(64'h0, 1'b0);
        send_row(64'h3, 1'b0);
        send_row(64'h0, 1'b0);
        send_row(64'h0, 1'b1);
        // Edge columns only
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);

        // Bits above the active count are ignored
        drain_results();
        write_columns(7'd5);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);
        // No column scored
        drain_results();
        write_columns(7'd0);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);
        // Count above the column total clamps to all columns
        drain_results();
        write_columns(7'd127);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);

        // Long matrix: pending counts and the total both saturate
        drain_results();
        send_row('1, 1'b0);
        repeat (1030) send_row('0, 1'b0);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);

        // Random matrices over three idling phases and nine register settings
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            for (int k = 0; k < 3; k++) begin
                drain_results();
                write_columns(cfg_seq[ph * 3 + k]);
                run_matrices(25);
            end
        end

        drain_results();
        board.close_out();
        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb_top
